// ----- hdl/iati_pkg.sv -----
// Shared types, register map and bit positions for the timer/interrupt interface adapter.
// Depends on nothing; every other file in hdl/ but iati_checker.sv imports it.
package iati_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // register map
  localparam logic [3:0] REG_PRA   = 4'd0;
  localparam logic [3:0] REG_PRB   = 4'd1;
  localparam logic [3:0] REG_DDRA  = 4'd2;
  localparam logic [3:0] REG_DDRB  = 4'd3;
  localparam logic [3:0] REG_TALO  = 4'd4;
  localparam logic [3:0] REG_TAHI  = 4'd5;
  localparam logic [3:0] REG_TBLO  = 4'd6;
  localparam logic [3:0] REG_TBHI  = 4'd7;
  localparam logic [3:0] REG_ICR   = 4'd13;
  localparam logic [3:0] REG_CRA   = 4'd14;
  localparam logic [3:0] REG_CRB   = 4'd15;

  // control register bits
  localparam int CTL_START   = 0;
  localparam int CTL_ONESHOT = 3;
  localparam int CTL_LOAD    = 4;
  localparam int CTL_CASCADE = 6;

  // interrupt flag bits
  localparam int FLAG_TA = 0;
  localparam int FLAG_TB = 1;
  localparam int FLAG_IR = 7;
  localparam int ICR_SET = 7;

  localparam logic [7:0] IRQ_READ_MASK   = 8'h9F;
  localparam logic [7:0] CRA_READ_MASK   = 8'hEF;
  localparam logic [7:0] CTL_STORE_MASK  = 8'hEF;

  typedef struct packed {
    func_t       func;
    logic [3:0]  reg_addr;
    logic [7:0]  write_data;
    logic [7:0]  elapsed;
    logic [7:0]  pins_a;
    logic [7:0]  pins_b;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_out;
    logic [7:0] drive_a;
    logic [7:0] drive_b;
  } result_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic [7:0]  ctl;
    logic        uflow;
  } tmr_res_t;

endpackage

// ----- hdl/iati_timer.sv -----
// One 16-bit down-counter step: count down by a number of cycles, reload or stop on underflow.
// Depends on iati_pkg (tmr_res_t, control bit positions).
module iati_timer import iati_pkg::*; (
  input  logic [15:0] cnt,
  input  logic [15:0] latch,
  input  logic [7:0]  ctl,
  input  logic [7:0]  cyc,
  output tmr_res_t    res
);

  logic        under;
  logic [7:0]  over;
  logic [15:0] over_w;
  logic [15:0] reload;

  always_comb begin
    under  = (cnt <= {8'h00, cyc});
    // only meaningful when under is set, so the count fits in 8 bits
    over   = cyc - cnt[7:0];
    over_w = {8'h00, over};
    reload = (over_w >= latch) ? 16'h0000 : (latch - over_w);

    res.ctl   = ctl;
    res.uflow = under;
    if (under) begin
      if (ctl[CTL_ONESHOT]) begin
        res.cnt            = 16'h0000;
        res.ctl[CTL_START] = 1'b0;
      end else begin
        res.cnt = reload;
      end
    end else begin
      res.cnt = cnt - {8'h00, cyc};
    end
  end

endmodule

// ----- hdl/iati_regs.sv -----
// Register file, timer control and interrupt logic; applies one transaction per enable.
// Depends on iati_pkg and iati_timer.
module iati_regs import iati_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  output result_t res
);

  logic [7:0]  irq_flags_r,  irq_flags_nxt;
  logic [4:0]  irq_enable_r, irq_enable_nxt;
  logic [7:0]  ctrl_a_r,     ctrl_a_nxt;
  logic [7:0]  ctrl_b_r,     ctrl_b_nxt;
  logic [15:0] latch_a_r,    latch_a_nxt;
  logic [15:0] latch_b_r,    latch_b_nxt;
  logic [15:0] count_a_r,    count_a_nxt;
  logic [15:0] count_b_r,    count_b_nxt;
  logic [7:0]  out_a_r,      out_a_nxt;
  logic [7:0]  out_b_r,      out_b_nxt;
  logic [7:0]  dir_a_r,      dir_a_nxt;
  logic [7:0]  dir_b_r,      dir_b_nxt;

  tmr_res_t   ta, tb;
  logic [7:0] b_cyc;
  logic       a_fire;
  logic       b_go;
  logic [7:0] rd;

  // timer B counts A underflows (one per tick) in cascade mode
  assign b_cyc = ctrl_b_r[CTL_CASCADE] ? 8'd1 : item.elapsed;

  iati_timer u_tmr_a (
    .cnt   (count_a_r),
    .latch (latch_a_r),
    .ctl   (ctrl_a_r),
    .cyc   (item.elapsed),
    .res   (ta)
  );

  iati_timer u_tmr_b (
    .cnt   (count_b_r),
    .latch (latch_b_r),
    .ctl   (ctrl_b_r),
    .cyc   (b_cyc),
    .res   (tb)
  );

  always_comb begin
    irq_flags_nxt  = irq_flags_r;
    irq_enable_nxt = irq_enable_r;
    ctrl_a_nxt     = ctrl_a_r;
    ctrl_b_nxt     = ctrl_b_r;
    latch_a_nxt    = latch_a_r;
    latch_b_nxt    = latch_b_r;
    count_a_nxt    = count_a_r;
    count_b_nxt    = count_b_r;
    out_a_nxt      = out_a_r;
    out_b_nxt      = out_b_r;
    dir_a_nxt      = dir_a_r;
    dir_b_nxt      = dir_b_r;
    rd             = 8'h00;

    a_fire = ctrl_a_r[CTL_START] && ta.uflow;
    b_go   = ctrl_b_r[CTL_START] && (ctrl_b_r[CTL_CASCADE] ? a_fire : 1'b1);

    unique case (item.func)
      FUNC_TICK: begin
        if (ctrl_a_r[CTL_START]) begin
          count_a_nxt = ta.cnt;
          ctrl_a_nxt  = ta.ctl;
          if (ta.uflow) begin
            irq_flags_nxt[FLAG_TA] = 1'b1;
          end
        end
        if (b_go) begin
          count_b_nxt = tb.cnt;
          ctrl_b_nxt  = tb.ctl;
          if (tb.uflow) begin
            irq_flags_nxt[FLAG_TB] = 1'b1;
          end
        end
        irq_flags_nxt[FLAG_IR] = |(irq_flags_nxt[4:0] & irq_enable_r);
      end
      FUNC_READ: begin
        unique case (item.reg_addr)
          REG_PRA:  rd = (item.pins_a & ~dir_a_r) | (out_a_r & dir_a_r);
          REG_PRB:  rd = (item.pins_b & ~dir_b_r) | (out_b_r & dir_b_r);
          REG_DDRA: rd = dir_a_r;
          REG_DDRB: rd = dir_b_r;
          REG_TALO: rd = count_a_r[7:0];
          REG_TAHI: rd = count_a_r[15:8];
          REG_TBLO: rd = count_b_r[7:0];
          REG_TBHI: rd = count_b_r[15:8];
          REG_ICR: begin
            rd            = irq_flags_r & IRQ_READ_MASK;
            irq_flags_nxt = 8'h00;
          end
          REG_CRA:  rd = ctrl_a_r & CRA_READ_MASK;
          default:  rd = 8'h00;
        endcase
      end
      FUNC_WRITE: begin
        unique case (item.reg_addr)
          REG_PRA:  out_a_nxt = item.write_data;
          REG_PRB:  out_b_nxt = item.write_data;
          REG_DDRA: dir_a_nxt = item.write_data;
          REG_DDRB: dir_b_nxt = item.write_data;
          REG_TALO: latch_a_nxt[7:0] = item.write_data;
          REG_TAHI: begin
            latch_a_nxt[15:8] = item.write_data;
            if (!ctrl_a_r[CTL_START]) begin
              count_a_nxt = {item.write_data, latch_a_r[7:0]};
            end
          end
          REG_TBLO: latch_b_nxt[7:0] = item.write_data;
          REG_TBHI: begin
            latch_b_nxt[15:8] = item.write_data;
            if (!ctrl_b_r[CTL_START]) begin
              count_b_nxt = {item.write_data, latch_b_r[7:0]};
            end
          end
          REG_ICR: begin
            if (item.write_data[ICR_SET]) begin
              irq_enable_nxt = irq_enable_r | item.write_data[4:0];
            end else begin
              irq_enable_nxt = irq_enable_r & ~item.write_data[4:0];
            end
          end
          REG_CRA: begin
            ctrl_a_nxt = item.write_data & CTL_STORE_MASK;
            if (item.write_data[CTL_LOAD]) begin
              count_a_nxt = latch_a_r;
            end
          end
          REG_CRB: begin
            ctrl_b_nxt = item.write_data & CTL_STORE_MASK;
            if (item.write_data[CTL_LOAD]) begin
              count_b_nxt = latch_b_r;
            end
          end
          default: ;
        endcase
      end
      FUNC_NOP: ;
      default: ;
    endcase

    res.read_data = rd;
    res.irq_out   = irq_flags_nxt[FLAG_IR];
    res.drive_a   = out_a_nxt & dir_a_nxt;
    res.drive_b   = out_b_nxt & dir_b_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irq_flags_r  <= '0;
      irq_enable_r <= '0;
      ctrl_a_r     <= '0;
      ctrl_b_r     <= '0;
      latch_a_r    <= '0;
      latch_b_r    <= '0;
      count_a_r    <= '0;
      count_b_r    <= '0;
      out_a_r      <= '0;
      out_b_r      <= '0;
      dir_a_r      <= '0;
      dir_b_r      <= '0;
    end else if (step) begin
      irq_flags_r  <= irq_flags_nxt;
      irq_enable_r <= irq_enable_nxt;
      ctrl_a_r     <= ctrl_a_nxt;
      ctrl_b_r     <= ctrl_b_nxt;
      latch_a_r    <= latch_a_nxt;
      latch_b_r    <= latch_b_nxt;
      count_a_r    <= count_a_nxt;
      count_b_r    <= count_b_nxt;
      out_a_r      <= out_a_nxt;
      out_b_r      <= out_b_nxt;
      dir_a_r      <= dir_a_nxt;
      dir_b_r      <= dir_b_nxt;
    end
  end

endmodule

// ----- hdl/interface_adapter_timers_irq.sv -----
// Timer/interrupt interface adapter, top level: input register, register file, result register.
// An accepted input transaction passes through the input register and then the result register to out_*.
// Throughput: one transaction per cycle while out_stall does not hold the result register; each is applied in a
// single pass through iati_regs. Reset (rst_n low, synchronous) empties both pipeline registers and zeroes
// all register-file and timer state. Depends on iati_pkg and iati_regs.
module interface_adapter_timers_irq import iati_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_elapsed,
  input  logic [7:0] in_pins_a,
  input  logic [7:0] in_pins_b,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_data,
  output logic       out_irq_out,
  output logic [7:0] out_drive_a,
  output logic [7:0] out_drive_b
);

  logic    in_valid_r;
  item_t   item_r;
  logic    out_valid_r;
  result_t res_r;
  result_t res_nxt;
  logic    advance;
  logic    in_take;

  // result register can take a new value when empty or being drained
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  iati_regs u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_valid_r && advance),
    .item  (item_r),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_valid_r || advance) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.func       <= func_t'(in_func);
      item_r.reg_addr   <= in_reg_addr;
      item_r.write_data <= in_write_data;
      item_r.elapsed    <= in_elapsed;
      item_r.pins_a     <= in_pins_a;
      item_r.pins_b     <= in_pins_b;
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = res_r.read_data;
  assign out_irq_out   = res_r.irq_out;
  assign out_drive_a   = res_r.drive_a;
  assign out_drive_b   = res_r.drive_b;

endmodule

// ----- hdl/iati_checker.sv -----
// Port-level checks for interface_adapter_timers_irq, attached by the bind at the end.
// Depends only on the top level's ports.
module iati_port_checks (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_read_data,
  input logic       out_irq_out,
  input logic [7:0] out_drive_a,
  input logic [7:0] out_drive_b
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) && $stable(out_irq_out)
      && $stable(out_drive_a) && $stable(out_drive_b))
    else $error("stalled result changed");

  // input only backs up when the result side is full and stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a held-off input transaction keeps the output occupied next cycle
  a_stall_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> out_valid)
    else $error("output emptied while input was stalled");

endmodule

bind interface_adapter_timers_irq iati_port_checks u_iati_port_checks (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_read_data (out_read_data),
  .out_irq_out   (out_irq_out),
  .out_drive_a   (out_drive_a),
  .out_drive_b   (out_drive_b)
);

// ----- tb/iati_checker.sv -----
// Checker for the timer/interrupt adapter: watches both channels, predicts every
// result from its own copy of the register file and timers, and counts mismatches.
// Depends on iati_pkg.
module iati_checker import iati_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [1:0] in_func,
  input  logic [3:0] in_reg_addr,
  input  logic [7:0] in_write_data,
  input  logic [7:0] in_elapsed,
  input  logic [7:0] in_pins_a,
  input  logic [7:0] in_pins_b,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_read_data,
  input  logic       out_irq_out,
  input  logic [7:0] out_drive_a,
  input  logic [7:0] out_drive_b,
  output int         mismatch_count,
  output int         results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted peripheral state
  logic [7:0]  irq_flags_q;
  logic [4:0]  irq_en_q;
  logic [7:0]  cra_q, crb_q;
  logic [15:0] ta_latch, tb_latch, ta_count, tb_count;
  logic [7:0]  pa_out, pb_out, pa_dir, pb_dir;

  result_t owed_results[$];

  task automatic run_timer(inout logic [15:0] cnt, input logic [15:0] latch,
                           inout logic [7:0] ctl, input int unsigned cyc,
                           output logic uflow);
    int unsigned overshoot;
    if (cnt <= cyc) begin
      overshoot = cyc - cnt;
      if (ctl[CTL_ONESHOT]) begin
        cnt = '0;
        ctl[CTL_START] = 1'b0;
      end else begin
        // reload minus overshoot, clamped at zero
        cnt = (overshoot >= latch) ? 16'd0 : latch - overshoot[15:0];
      end
      uflow = 1'b1;
    end else begin
      cnt = cnt - cyc[15:0];
      uflow = 1'b0;
    end
  endtask

  task automatic advance_timers(input int unsigned cyc);
    logic uf;
    if (cra_q[CTL_START]) begin
      run_timer(ta_count, ta_latch, cra_q, cyc, uf);
      if (uf) begin
        irq_flags_q[FLAG_TA] = 1'b1;
        // cascaded B takes one count per tick from A underflows
        if (crb_q[CTL_START] && crb_q[CTL_CASCADE]) begin
          run_timer(tb_count, tb_latch, crb_q, 1, uf);
          if (uf) irq_flags_q[FLAG_TB] = 1'b1;
        end
      end
    end
    if (crb_q[CTL_START] && !crb_q[CTL_CASCADE]) begin
      run_timer(tb_count, tb_latch, crb_q, cyc, uf);
      if (uf) irq_flags_q[FLAG_TB] = 1'b1;
    end
    irq_flags_q[FLAG_IR] = |(irq_flags_q[4:0] & irq_en_q);
  endtask

  task automatic read_register(input logic [3:0] addr, input logic [7:0] pa,
                               input logic [7:0] pb, output logic [7:0] val);
    case (addr)
      REG_PRA:  val = (pa & ~pa_dir) | (pa_out & pa_dir);
      REG_PRB:  val = (pb & ~pb_dir) | (pb_out & pb_dir);
      REG_DDRA: val = pa_dir;
      REG_DDRB: val = pb_dir;
      REG_TALO: val = ta_count[7:0];
      REG_TAHI: val = ta_count[15:8];
      REG_TBLO: val = tb_count[7:0];
      REG_TBHI: val = tb_count[15:8];
      REG_ICR: begin
        val = irq_flags_q & IRQ_READ_MASK;
        irq_flags_q = '0;
      end
      REG_CRA:  val = cra_q & CRA_READ_MASK;
      default:  val = '0;
    endcase
  endtask

  task automatic write_register(input logic [3:0] addr, input logic [7:0] d);
    case (addr)
      REG_PRA:  pa_out = d;
      REG_PRB:  pb_out = d;
      REG_DDRA: pa_dir = d;
      REG_DDRB: pb_dir = d;
      REG_TALO: ta_latch[7:0] = d;
      REG_TAHI: begin
        ta_latch[15:8] = d;
        if (!cra_q[CTL_START]) ta_count = ta_latch;
      end
      REG_TBLO: tb_latch[7:0] = d;
      REG_TBHI: begin
        tb_latch[15:8] = d;
        if (!crb_q[CTL_START]) tb_count = tb_latch;
      end
      REG_ICR: begin
        if (d[ICR_SET]) irq_en_q = irq_en_q | d[4:0];
        else irq_en_q = irq_en_q & ~d[4:0];
      end
      REG_CRA: begin
        cra_q = d & CTL_STORE_MASK;
        if (d[CTL_LOAD]) ta_count = ta_latch;
      end
      REG_CRB: begin
        crb_q = d & CTL_STORE_MASK;
        if (d[CTL_LOAD]) tb_count = tb_latch;
      end
      default: ;
    endcase
  endtask

  task automatic predict_bus_result(output result_t res);
    logic [7:0] rd;
    rd = '0;
    case (func_t'(in_func))
      FUNC_TICK:  advance_timers(in_elapsed);
      FUNC_READ:  read_register(in_reg_addr, in_pins_a, in_pins_b, rd);
      FUNC_WRITE: write_register(in_reg_addr, in_write_data);
      default: ;
    endcase
    res.read_data = rd;
    res.irq_out   = irq_flags_q[FLAG_IR];
    res.drive_a   = pa_out & pa_dir;
    res.drive_b   = pb_out & pb_dir;
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %02h, got %02h", $time, field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (!rst_n) begin
      irq_flags_q = '0; irq_en_q = '0; cra_q = '0; crb_q = '0;
      ta_latch = '0; tb_latch = '0; ta_count = '0; tb_count = '0;
      pa_out = '0; pb_out = '0; pa_dir = '0; pb_dir = '0;
      owed_results.delete();
      mismatch_count = 0;
    end else begin
      // a transaction passes through the input and result registers, so one accepted at this
      // edge cannot be the one leaving at it
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: result with none expected, expected none, got %02h %b %02h %02h",
                   $time, out_read_data, out_irq_out, out_drive_a, out_drive_b);
          mismatch_count++;
        end else begin
          want = owed_results.pop_front();
          check_field("read_data", want.read_data, out_read_data);
          check_field("irq_out", {7'd0, want.irq_out}, {7'd0, out_irq_out});
          check_field("drive_a", want.drive_a, out_drive_a);
          check_field("drive_b", want.drive_b, out_drive_b);
        end
      end
      if (in_valid && !in_stall) begin
        predict_bus_result(want);
        owed_results.push_back(want);
      end
    end
    results_owed = owed_results.size();
  end

endmodule

// ----- tb/tb_top.sv -----
// Top of the timer/interrupt adapter testbench: clock, reset, bus stimulus, result
// back-pressure, watchdog and verdict. Depends on iati_pkg, iati_checker and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import iati_pkg::*;

  localparam logic [3:0] REG_SDR = 4'd12;   // serial data, read as zero
  localparam int PHASE_ITEMS   = 280;
  localparam int PHASES        = 4;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int LONG_HOLD_AT  = 450;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = FUNC_NOP;
  logic [3:0] in_reg_addr = '0;
  logic [7:0] in_write_data = '0;
  logic [7:0] in_elapsed = '0;
  logic [7:0] in_pins_a = '0;
  logic [7:0] in_pins_b = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_data;
  logic       out_irq_out;
  logic [7:0] out_drive_a;
  logic [7:0] out_drive_b;

  int  mismatch_count;
  int  results_owed;
  int  items_sent = 0;
  int  results_taken = 0;
  int  idle_cycles = 0;
  bit  sender_no_gaps = 1'b0;

  always #5 clk = ~clk;

  interface_adapter_timers_irq i_dut (.*);

  iati_checker i_checker (.*);

  // watchdog: ends the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) results_taken++;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // result back-pressure, with one long hold-off while the sender keeps going
  initial begin : receiver
    int  stall_left, free_left, r;
    bit  long_done;
    stall_left = 0;
    free_left  = 20;
    long_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_done && results_taken >= LONG_HOLD_AT) begin
        long_done  = 1'b1;
        stall_left = 150;
        free_left  = 0;
      end
      if (stall_left == 0 && free_left == 0) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          free_left = $urandom_range(40, 120);
        end else begin
          stall_left = (r < 85) ? $urandom_range(1, 3) : $urandom_range(6, 30);
          free_left  = $urandom_range(0, 6);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        free_left--;
      end
    end
  end

  function automatic int pick_send_gap();
    int r;
    if (sender_no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input func_t f, input logic [3:0] addr,
                           input logic [7:0] data, input logic [7:0] cyc);
    int gap;
    gap = pick_send_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func       <= f;
    in_reg_addr   <= addr;
    in_write_data <= data;
    in_elapsed    <= cyc;
    in_pins_a     <= 8'($urandom_range(0, 255));
    in_pins_b     <= 8'($urandom_range(0, 255));
    in_valid      <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [7:0] data);
    send_item(FUNC_WRITE, addr, data, 8'($urandom_range(0, 255)));
  endtask

  task automatic read_reg(input logic [3:0] addr);
    send_item(FUNC_READ, addr, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endtask

  task automatic tick_for(input logic [7:0] cyc);
    send_item(FUNC_TICK, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), cyc);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0) @(negedge clk);
  endtask

  // set up one timer, let it run for a few ticks and collect its flags
  task automatic program_timer(input bit use_b);
    logic [7:0] ctl;
    write_reg(use_b ? REG_TBLO : REG_TALO, 8'($urandom_range(0, 255)));
    write_reg(use_b ? REG_TBHI : REG_TAHI, 8'($urandom_range(0, 1)));
    write_reg(REG_ICR, (8'd1 << ICR_SET) | 8'($urandom_range(0, 31)));
    ctl = 8'($urandom_range(0, 255));
    ctl[CTL_START] = 1'b1;
    if (!use_b) ctl[CTL_CASCADE] = 1'b0;
    write_reg(use_b ? REG_CRB : REG_CRA, ctl);
    repeat ($urandom_range(2, 6)) tick_for(8'($urandom_range(0, 255)));
    read_reg(REG_ICR);
  endtask

  task automatic random_item();
    int r;
    logic [3:0] addr;
    logic [7:0] data;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      tick_for(8'(($urandom_range(0, 9) < 6) ? $urandom_range(0, 15)
                                              : $urandom_range(0, 255)));
    end else if (r < 65) begin
      read_reg(4'($urandom_range(0, 15)));
    end else if (r < 95) begin
      addr = 4'($urandom_range(0, 15));
      data = 8'($urandom_range(0, 255));
      // keep most latches short so timers wrap often
      if ((addr == REG_TAHI || addr == REG_TBHI) && $urandom_range(0, 3) != 0)
        data = 8'($urandom_range(0, 1));
      if ((addr == REG_CRA || addr == REG_CRB) && $urandom_range(0, 9) < 7)
        data[CTL_START] = 1'b1;
      write_reg(addr, data);
    end else begin
      send_item(FUNC_NOP, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int phase_end;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ports and direction masking
    write_reg(REG_DDRA, 8'hFF);
    write_reg(REG_PRA, 8'hA5);
    read_reg(REG_PRA);
    write_reg(REG_DDRB, 8'h0F);
    write_reg(REG_PRB, 8'hFF);
    read_reg(REG_PRB);
    // continuous timer A whose overshoot exceeds the latch, then a zero count
    write_reg(REG_TALO, 8'h10);
    write_reg(REG_TAHI, 8'h00);
    write_reg(REG_ICR, 8'h83);
    write_reg(REG_CRA, 8'h01);
    tick_for(8'hFF);
    read_reg(REG_ICR);
    tick_for(8'h00);
    // one-shot B cascaded on A underflows
    write_reg(REG_TBLO, 8'h01);
    write_reg(REG_TBHI, 8'h00);
    write_reg(REG_CRB, 8'h59);
    tick_for(8'h00);
    tick_for(8'h03);
    // one-shot A with load, control reads, unused registers
    write_reg(REG_CRA, 8'h19);
    tick_for(8'hFF);
    read_reg(REG_CRA);
    read_reg(REG_CRB);
    write_reg(REG_ICR, 8'h1F);
    write_reg(REG_SDR, 8'hFF);
    read_reg(REG_SDR);
    send_item(FUNC_NOP, 4'hF, 8'hFF, 8'hFF);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      sender_no_gaps = (phase == 2);
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if ($urandom_range(0, 99) < 20) program_timer(1'($urandom_range(0, 1)));
        else random_item();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
